// ----- rtl/core/key_report_to_key_events_macros.svh -----
// Assertion macros used by the key report converter.
// Each macro takes a label, the clock, the active-low reset and a property.
`ifndef KEY_REPORT_TO_KEY_EVENTS_MACROS_SVH
`define KEY_REPORT_TO_KEY_EVENTS_MACROS_SVH
`ifndef SYNTHESIS
`define KRE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("key report converter: property failed");
`define KRE_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("key report converter: forbidden condition seen");
`else
`define KRE_ASSERT(lbl, clk, rstn, prop)
`define KRE_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ----- rtl/core/kre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key report converter package
// Item types, command and status structs, slot numbering and helpers.
// ----------------------------------------------------------------------------
package kre_pkg;

  localparam int unsigned CODE_W    = 10;
  localparam int unsigned SC_W      = 8;
  localparam int unsigned MOD_COUNT = 4;

  // Command field of an input item.
  localparam logic CMD_REPORT    = 1'b0;
  localparam logic CMD_MAP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    KIND_KEY  = 2'd0,
    KIND_LED  = 2'd1,
    KIND_SYNC = 2'd2
  } kind_e;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        lead_byte;
    logic [3:0]        modifier_bits;
    logic [SC_W-1:0]   scancode_a;
    logic [SC_W-1:0]   scancode_b;
    logic [SC_W-1:0]   map_index;
    logic [CODE_W-1:0] map_code;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] key_code;
    logic              pressed;
    logic [3:0]        led_command;
    logic              last;
  } out_item_t;

  // Result slots of one report, visited in ascending order.
  //   0,2,4,6   : LED commands of shift, green, orange, people
  //   1,3,5,7   : presses of the modifiers
  //   8..11     : sorted presses and releases of ordinary keys
  //   12..15    : releases of the modifiers
  //   16        : sync
  localparam int unsigned NUM_SLOTS         = 17;
  localparam int unsigned SLOT_W            = 5;
  localparam logic [SLOT_W-1:0] SLOT_EVENT_BASE   = 5'd8;
  localparam logic [SLOT_W-1:0] SLOT_RELEASE_BASE = 5'd12;
  localparam logic [SLOT_W-1:0] SLOT_SYNC         = 5'd16;

  typedef enum logic [1:0] {
    SK_LED,
    SK_KEY,
    SK_SYNC
  } slot_kind_e;

  typedef struct packed {
    logic              map_write;
    logic              load_report;
    logic              prep;
    logic              emit;
    logic [SLOT_W-1:0] slot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                 in_write;
    logic                 in_report_ok;
    logic [NUM_SLOTS-1:0] active;
    logic                 code_nz;
    logic                 out_free;
  } ctrl_sts_t;

  // One ordinary key event candidate.
  typedef struct packed {
    logic            vld;
    logic [SC_W-1:0] idx;
    logic            dir;
  } ev_t;

  function automatic slot_kind_e slot_kind(logic [SLOT_W-1:0] slot);
    slot_kind_e k;
    if (slot == SLOT_SYNC) begin
      k = SK_SYNC;
    end else if (slot < SLOT_EVENT_BASE && !slot[0]) begin
      k = SK_LED;
    end else begin
      k = SK_KEY;
    end
    return k;
  endfunction

  function automatic logic is_mod(logic [SC_W-1:0] sc);
    return (sc == 8'd1) || (sc == 8'd2) || (sc == 8'd4) || (sc == 8'd8);
  endfunction

  // True when a must be ordered after b; empty candidates sort to the end.
  function automatic logic ev_later(ev_t a, ev_t b);
    return {~a.vld, a.idx} > {~b.vld, b.idx};
  endfunction

endpackage

// ----- rtl/core/kre_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module kre_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/kre_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key report converter datapath
// Held-key state, event list, keymap and the output register.
// ----------------------------------------------------------------------------
module kre_datapath #(
  parameter int unsigned SCANCODE_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kre_pkg::in_item_t   in_i,
  input  kre_pkg::ctrl_cmd_t  cmd_i,
  output kre_pkg::ctrl_sts_t  sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kre_pkg::out_item_t  out_o
);

  localparam int unsigned IDX_W    = $clog2(SCANCODE_COUNT);
  localparam int unsigned SC_W     = kre_pkg::SC_W;
  localparam int unsigned CODE_W_L = kre_pkg::CODE_W;

  // Report held between acceptance and preparation.
  logic [3:0]      rpt_mods_q;
  logic [SC_W-1:0] rpt_a_q, rpt_b_q;

  // Held set left by the previous report.
  logic [3:0]      held_mods_q;
  logic [SC_W-1:0] held_key_q [2];
  logic [1:0]      held_vld_q;

  logic [3:0]      led_q;
  kre_pkg::ev_t    ev_q [4];

  logic [SCANCODE_COUNT-1:0] map_vld_q;
  logic                      map_vld_rd_q;

  logic                       out_valid_q;
  kre_pkg::out_item_t         out_q;

  // New held set.
  logic            a_ok, b_ok, n0_vld, n1_vld;
  logic [3:0]      new_mods;
  kre_pkg::ev_t    cand [4];
  kre_pkg::ev_t    s1 [4];
  kre_pkg::ev_t    s2 [4];
  kre_pkg::ev_t    srt [4];

  logic [kre_pkg::NUM_SLOTS-1:0] slot_active;

  always_comb begin
    a_ok = (rpt_a_q != '0) && ({1'b0, rpt_a_q} < 9'(SCANCODE_COUNT));
    b_ok = (rpt_b_q != '0) && ({1'b0, rpt_b_q} < 9'(SCANCODE_COUNT));
    for (int j = 0; j < kre_pkg::MOD_COUNT; j++) begin
      new_mods[j] = rpt_mods_q[j]
                  | (a_ok && rpt_a_q == (8'd1 << j))
                  | (b_ok && rpt_b_q == (8'd1 << j));
    end
    n0_vld = a_ok && !kre_pkg::is_mod(rpt_a_q);
    n1_vld = b_ok && !kre_pkg::is_mod(rpt_b_q) && !(n0_vld && rpt_b_q == rpt_a_q);

    cand[0].vld = n0_vld
                && !(held_vld_q[0] && held_key_q[0] == rpt_a_q)
                && !(held_vld_q[1] && held_key_q[1] == rpt_a_q);
    cand[0].idx = rpt_a_q;
    cand[0].dir = 1'b1;
    cand[1].vld = n1_vld
                && !(held_vld_q[0] && held_key_q[0] == rpt_b_q)
                && !(held_vld_q[1] && held_key_q[1] == rpt_b_q);
    cand[1].idx = rpt_b_q;
    cand[1].dir = 1'b1;
    for (int k = 0; k < 2; k++) begin
      cand[k+2].vld = held_vld_q[k]
                    && !(n0_vld && rpt_a_q == held_key_q[k])
                    && !(n1_vld && rpt_b_q == held_key_q[k]);
      cand[k+2].idx = held_key_q[k];
      cand[k+2].dir = 1'b0;
    end

    // Four-input sorting network.
    s1 = cand;
    if (kre_pkg::ev_later(cand[0], cand[1])) begin
      s1[0] = cand[1];
      s1[1] = cand[0];
    end
    if (kre_pkg::ev_later(cand[2], cand[3])) begin
      s1[2] = cand[3];
      s1[3] = cand[2];
    end
    s2 = s1;
    if (kre_pkg::ev_later(s1[0], s1[2])) begin
      s2[0] = s1[2];
      s2[2] = s1[0];
    end
    if (kre_pkg::ev_later(s1[1], s1[3])) begin
      s2[1] = s1[3];
      s2[3] = s1[1];
    end
    srt = s2;
    if (kre_pkg::ev_later(s2[1], s2[2])) begin
      srt[1] = s2[2];
      srt[2] = s2[1];
    end
  end

  always_comb begin
    slot_active = '0;
    slot_active[0] = new_mods[0] ^ held_mods_q[0];
    for (int j = 0; j < kre_pkg::MOD_COUNT; j++) begin
      slot_active[2*j+1] = new_mods[j] & ~held_mods_q[j];
      slot_active[12+j]  = held_mods_q[j] & ~new_mods[j];
    end
    for (int j = 1; j < kre_pkg::MOD_COUNT; j++) begin
      slot_active[2*j] = new_mods[j] & ~held_mods_q[j];
    end
    for (int k = 0; k < 4; k++) begin
      slot_active[8+k] = srt[k].vld;
    end
    slot_active[kre_pkg::SLOT_SYNC] = 1'b1;
  end

  assign sts_o.active = slot_active;

  // Per-slot decode.
  logic [SC_W-1:0]   key_idx;
  logic              key_down;
  logic [1:0]        led_no;
  logic              led_on;
  logic [CODE_W_L-1:0] code;
  logic [CODE_W_L-1:0] ram_rd;

  always_comb begin
    led_no = cmd_i.slot[2:1];
    led_on = (cmd_i.slot == '0) ? held_mods_q[0] : ~led_q[led_no];
    if (cmd_i.slot < kre_pkg::SLOT_EVENT_BASE) begin
      key_idx  = 8'd1 << cmd_i.slot[2:1];
      key_down = 1'b1;
    end else if (cmd_i.slot < kre_pkg::SLOT_RELEASE_BASE) begin
      key_idx  = ev_q[cmd_i.slot[1:0]].idx;
      key_down = ev_q[cmd_i.slot[1:0]].dir;
    end else begin
      key_idx  = 8'd1 << cmd_i.slot[1:0];
      key_down = 1'b0;
    end
  end

  logic map_wr_en;
  assign map_wr_en = cmd_i.map_write && ({1'b0, in_i.map_index} < 9'(SCANCODE_COUNT));

  kre_ram #(
    .WIDTH (CODE_W_L),
    .DEPTH (SCANCODE_COUNT)
  ) u_keymap (
    .clk_i     (clk_i),
    .wr_en_i   (map_wr_en),
    .wr_addr_i (in_i.map_index[IDX_W-1:0]),
    .wr_data_i (in_i.map_code),
    .rd_addr_i (key_idx[IDX_W-1:0]),
    .rd_data_o (ram_rd)
  );

  assign code          = map_vld_rd_q ? ram_rd : '0;
  assign sts_o.code_nz = (code != '0);
  assign sts_o.in_write     = (in_i.cmd == kre_pkg::CMD_MAP_WRITE);
  assign sts_o.in_report_ok = (in_i.cmd == kre_pkg::CMD_REPORT) && (in_i.lead_byte == '0);
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  kre_pkg::out_item_t emit_item;

  always_comb begin
    emit_item = '{kind: kre_pkg::KIND_SYNC, key_code: '0, pressed: 1'b0,
                  led_command: '0, last: 1'b0};
    unique case (kre_pkg::slot_kind(cmd_i.slot))
      kre_pkg::SK_LED: begin
        emit_item.kind        = kre_pkg::KIND_LED;
        emit_item.led_command = {led_on, 1'b0, led_no};
      end
      kre_pkg::SK_KEY: begin
        emit_item.kind     = kre_pkg::KIND_KEY;
        emit_item.key_code = code;
        emit_item.pressed  = key_down;
      end
      default: begin
        emit_item.kind = kre_pkg::KIND_SYNC;
        emit_item.last = 1'b1;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_report) begin
      rpt_mods_q <= in_i.modifier_bits;
      rpt_a_q    <= in_i.scancode_a;
      rpt_b_q    <= in_i.scancode_b;
    end
    if (cmd_i.prep) begin
      held_key_q[0] <= rpt_a_q;
      held_key_q[1] <= rpt_b_q;
      ev_q          <= srt;
    end
    if (cmd_i.emit) begin
      out_q <= emit_item;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mods_q  <= '0;
      held_vld_q   <= '0;
      led_q        <= '0;
      map_vld_q    <= '0;
      map_vld_rd_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      map_vld_rd_q <= map_vld_q[key_idx[IDX_W-1:0]];
      if (map_wr_en) begin
        map_vld_q[in_i.map_index[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd_i.prep) begin
        held_mods_q <= new_mods;
        held_vld_q  <= {n1_vld, n0_vld};
      end
      if (cmd_i.emit && kre_pkg::slot_kind(cmd_i.slot) == kre_pkg::SK_LED) begin
        led_q[led_no] <= led_on;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/core/kre_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key report converter controller
// Accepts items and walks the pending result slots of a report in order.
// ----------------------------------------------------------------------------
`include "key_report_to_key_events_macros.svh"

module kre_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kre_pkg::ctrl_sts_t  sts_i,
  output kre_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_ISSUE,
    ST_LOOK
  } state_e;

  state_e                        state_q, state_d;
  logic [kre_pkg::NUM_SLOTS-1:0] pending_q, pending_d;
  logic [kre_pkg::SLOT_W-1:0]    slot;
  logic [kre_pkg::NUM_SLOTS-1:0] slot_bit;

  // Lowest pending slot.
  always_comb begin
    slot = '0;
    for (int i = kre_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (pending_q[i]) begin
        slot = kre_pkg::SLOT_W'(i);
      end
    end
  end

  assign slot_bit = kre_pkg::NUM_SLOTS'(1) << slot;

  always_comb begin
    state_d           = state_q;
    pending_d         = pending_q;
    cmd_o             = '0;
    cmd_o.slot        = slot;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_write) begin
            cmd_o.map_write = 1'b1;
          end else if (sts_i.in_report_ok) begin
            cmd_o.load_report = 1'b1;
            state_d           = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        pending_d  = sts_i.active;
        state_d    = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (kre_pkg::slot_kind(slot) == kre_pkg::SK_KEY) begin
          state_d = ST_LOOK;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          pending_d  = pending_q & ~slot_bit;
          if (kre_pkg::slot_kind(slot) == kre_pkg::SK_SYNC) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_LOOK: begin
        if (!sts_i.code_nz) begin
          pending_d = pending_q & ~slot_bit;
          state_d   = ST_ISSUE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          pending_d  = pending_q & ~slot_bit;
          state_d    = ST_ISSUE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= '0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // The sync slot stays pending until the very end of a report.
  `KRE_ASSERT(a_sync_pending, clk_i, rst_ni,
              (state_q == ST_ISSUE || state_q == ST_LOOK) |-> pending_q[kre_pkg::SLOT_SYNC])
  // A result is never loaded over one that is still stalled.
  `KRE_ASSERT(a_emit_free, clk_i, rst_ni, cmd_o.emit |-> sts_i.out_free)
  // The keymap lookup state only ever serves key slots.
  `KRE_ASSERT_NEVER(a_look_key, clk_i, rst_ni,
                    state_q == ST_LOOK && kre_pkg::slot_kind(slot) != kre_pkg::SK_KEY)

endmodule

// ----- rtl/core/key_report_to_key_events.sv -----
`timescale 1ns / 1ps
// A report is loaded on acceptance, prepared, and then its pending result slots are issued in order.
// Each key slot (mapped or not) waits on its keymap lookup before it is issued or skipped.
// The input is stalled until a report's sync item is issued; output stalls hold the slot walk.
// Keymap writes and reports with a nonzero header are taken while idle and start no slot walk.
// Reset clears the held keys, the LED state and the keymap valid bits at once; no sweep.
// ----------------------------------------------------------------------------
// Key report to key events converter
// Compares each keypad report with the previous one and emits LED commands,
// key presses and releases and a closing sync item.
// ----------------------------------------------------------------------------
//
// Structure
// The controller holds a mask of result slots that a report needs and visits
// them lowest first. The slot numbering fixes the emission order: the shift
// LED command, the modifier LED toggles each followed by that modifier's press,
// the ordinary keys in ascending scancode order, the modifier releases, and
// the sync item last.
//
// Because the held set is rebuilt from scratch on every report it never holds
// more than the four modifiers and two ordinary scancodes. The datapath
// therefore keeps it as a modifier nibble and two scancode registers rather
// than a full bitmap. The up to four ordinary key changes of a report are put
// in order by a small sorting network in the cycle after acceptance.
//
// The keymap lives in a RAM with a registered read. Every entry carries a
// valid bit that reset clears, and an entry that was never written reads as
// zero, which marks the scancode as unmapped: such a key slot produces no item.
//
// The result item is held in an output register, so the slot walk simply
// waits while the downstream side stalls.
// ----------------------------------------------------------------------------
module key_report_to_key_events #(
  parameter int unsigned SCANCODE_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kre_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kre_pkg::out_item_t  out_o
);

  kre_pkg::ctrl_cmd_t cmd;
  kre_pkg::ctrl_sts_t sts;

  kre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kre_datapath #(
    .SCANCODE_COUNT (SCANCODE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
